// File: hw/rtl/mmad_pkg.sv
// Shared types and codes for the memory map address decoder.
package mmad_pkg;

	typedef enum logic [2:0] {
		CMD_CPU_READ   = 3'd0,
		CMD_CPU_WRITE  = 3'd1,
		CMD_LOAD_READ  = 3'd2,
		CMD_LOAD_WRITE = 3'd3,
		CMD_PRELOAD    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_NOP     = 2'd0,
		KIND_RAM     = 2'd1,
		KIND_ROM     = 2'd2,
		KIND_HANDLER = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OUT_MEM_READ       = 4'd0,
		OUT_HANDLER_READ   = 4'd1,
		OUT_HANDLER_WRITE  = 4'd2,
		OUT_NOP            = 4'd3,
		OUT_ROM_BLOCKED    = 4'd4,
		OUT_MEM_WRITE      = 4'd5,
		OUT_UNMAPPED_READ  = 4'd6,
		OUT_UNMAPPED_WRITE = 4'd7,
		OUT_LOAD_ACK       = 4'd8
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_DECODE = 2'd1,
		ST_RESP   = 2'd2
	} state_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] addr_lo;
		logic [15:0] addr_hi;
		kind_t       kind;
		logic [7:0]  handler;
	} region_t;

	typedef struct packed {
		logic [3:0] index;
		region_t    entry;
	} region_load_t;

	typedef struct packed {
		logic        hit;
		kind_t       kind;
		logic [7:0]  handler;
		logic [15:0] addr_lo;
	} region_hit_t;

endpackage

// File: hw/rtl/mmad_region_table.sv
// Region table with parallel range compare and lowest-slot priority select.
module mmad_region_table #(
	parameter int REGIONS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  mmad_pkg::region_load_t load_entry,
	input  logic                   capture,
	input  logic [15:0]            lookup_addr,
	output mmad_pkg::region_hit_t  hit
);

	logic [REGIONS-1:0] valid_q;
	mmad_pkg::region_t  entry_q [REGIONS];
	logic [REGIONS-1:0] match_q;
	logic [REGIONS-1:0] match_d;
	logic [REGIONS-1:0] first_oh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (load) begin
			for (int i = 0; i < REGIONS; i++) begin
				if (32'(load_entry.index) == i) begin
					valid_q[i] <= load_entry.entry.valid;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < REGIONS; i++) begin
				if (32'(load_entry.index) == i) begin
					entry_q[i] <= load_entry.entry;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < REGIONS; i++) begin
			match_d[i] = valid_q[i] && (lookup_addr >= entry_q[i].addr_lo)
				&& (lookup_addr <= entry_q[i].addr_hi);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
		end else if (capture) begin
			match_q <= match_d;
		end
	end

	// isolate lowest set bit
	assign first_oh = match_q & (~match_q + REGIONS'(1));

	always_comb begin
		hit.hit     = |match_q;
		hit.kind    = mmad_pkg::KIND_NOP;
		hit.handler = '0;
		hit.addr_lo = '0;
		for (int i = 0; i < REGIONS; i++) begin
			if (first_oh[i]) begin
				hit.kind    = mmad_pkg::kind_t'(hit.kind | entry_q[i].kind);
				hit.handler = hit.handler | entry_q[i].handler;
				hit.addr_lo = hit.addr_lo | entry_q[i].addr_lo;
			end
		end
	end

endmodule

// File: hw/rtl/memory_map_address_decoder_core.sv
// Memory map address decoder: region lookup, local memory and result register.
// A request passes lookup, memory access and response load in turn; rsp_stall can hold the response.
// A new request is taken only after the previous one has loaded its response;
// a request is taken while a finished response still waits in the output register.
// Reset clears both region tables' valid bits and all control state;
// local memory is not cleared and holds no defined value until written.
module memory_map_address_decoder_core #(
	parameter int REGIONS      = 16,
	parameter int ADDRESS_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	input  logic [3:0]  region_index,
	input  logic [15:0] region_start,
	input  logic [15:0] region_end,
	input  logic [1:0]  region_kind,
	input  logic [7:0]  region_handler,
	input  logic        region_valid,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  read_data,
	output logic [3:0]  outcome,
	output logic [7:0]  handler_id,
	output logic [15:0] handler_offset,
	output logic [7:0]  handler_data
);

	localparam int MEM_DEPTH = 1 << ADDRESS_BITS;

	mmad_pkg::state_t state_q, state_d;

	logic                    req_xfer;
	logic                    rsp_load;
	logic [ADDRESS_BITS+15:0] addr_wide;
	logic [ADDRESS_BITS-1:0] maddr_in;
	logic [15:0]             addr_in16;

	mmad_pkg::cmd_t          cmd_q;
	logic [ADDRESS_BITS-1:0] maddr_q;
	logic [7:0]              data_q;
	logic [15:0]             addr16;

	mmad_pkg::region_load_t  load_entry;
	mmad_pkg::region_hit_t   rd_hit, wr_hit;
	logic                    load_rd, load_wr;

	logic [7:0]              mem_q [MEM_DEPTH];
	logic [7:0]              mem_rdata_q;
	logic                    mem_re, mem_we;

	logic                    dec_re, dec_we, dec_rd_sel;
	mmad_pkg::outcome_t      dec_outcome;
	logic [7:0]              dec_hid, dec_hdata;
	logic [15:0]             dec_hoff;

	logic                    rd_sel_q;
	mmad_pkg::outcome_t      res_outcome_q;
	logic [7:0]              res_hid_q, res_hdata_q;
	logic [15:0]             res_hoff_q;
	logic                    rsp_valid_q;

	assign req_xfer  = req_valid && !req_stall;
	assign rsp_load  = (state_q == mmad_pkg::ST_RESP) && (!rsp_valid_q || !rsp_stall);

	assign addr_wide = {{ADDRESS_BITS{1'b0}}, address};
	assign maddr_in  = addr_wide[ADDRESS_BITS-1:0];
	assign addr_in16 = 16'(maddr_in);
	assign addr16    = 16'(maddr_q);

	assign load_entry.index         = region_index;
	assign load_entry.entry.valid   = region_valid;
	assign load_entry.entry.addr_lo = region_start;
	assign load_entry.entry.addr_hi = region_end;
	assign load_entry.entry.kind    = mmad_pkg::kind_t'(region_kind);
	assign load_entry.entry.handler = region_handler;

	assign load_rd = req_xfer && (command == mmad_pkg::CMD_LOAD_READ);
	assign load_wr = req_xfer && (command == mmad_pkg::CMD_LOAD_WRITE);

	mmad_region_table #(.REGIONS(REGIONS)) u_rd_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_rd),
		.load_entry (load_entry),
		.capture    (req_xfer),
		.lookup_addr(addr_in16),
		.hit        (rd_hit)
	);

	mmad_region_table #(.REGIONS(REGIONS)) u_wr_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_wr),
		.load_entry (load_entry),
		.capture    (req_xfer),
		.lookup_addr(addr_in16),
		.hit        (wr_hit)
	);

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			cmd_q   <= mmad_pkg::cmd_t'(command);
			maddr_q <= maddr_in;
			data_q  <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmad_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmad_pkg::ST_IDLE: begin
				if (req_valid) state_d = mmad_pkg::ST_DECODE;
			end
			mmad_pkg::ST_DECODE: state_d = mmad_pkg::ST_RESP;
			mmad_pkg::ST_RESP: begin
				if (rsp_load) state_d = mmad_pkg::ST_IDLE;
			end
			default: state_d = mmad_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != mmad_pkg::ST_IDLE);
		mem_re    = (state_q == mmad_pkg::ST_DECODE) && dec_re;
		mem_we    = (state_q == mmad_pkg::ST_DECODE) && dec_we;
	end

	always_comb begin
		dec_re      = 1'b0;
		dec_we      = 1'b0;
		dec_rd_sel  = 1'b0;
		dec_outcome = mmad_pkg::OUT_NOP;
		dec_hid     = '0;
		dec_hoff    = '0;
		dec_hdata   = '0;
		unique case (cmd_q)
			mmad_pkg::CMD_CPU_READ: begin
				if (!rd_hit.hit) begin
					dec_re      = 1'b1;
					dec_rd_sel  = 1'b1;
					dec_outcome = mmad_pkg::OUT_UNMAPPED_READ;
				end else if (rd_hit.kind == mmad_pkg::KIND_NOP) begin
					dec_outcome = mmad_pkg::OUT_NOP;
				end else if (rd_hit.kind == mmad_pkg::KIND_HANDLER) begin
					dec_outcome = mmad_pkg::OUT_HANDLER_READ;
					dec_hid     = rd_hit.handler;
					dec_hoff    = addr16 - rd_hit.addr_lo;
				end else begin
					dec_re      = 1'b1;
					dec_rd_sel  = 1'b1;
					dec_outcome = mmad_pkg::OUT_MEM_READ;
				end
			end
			mmad_pkg::CMD_CPU_WRITE: begin
				if (!wr_hit.hit) begin
					dec_we      = 1'b1;
					dec_outcome = mmad_pkg::OUT_UNMAPPED_WRITE;
				end else begin
					unique case (wr_hit.kind)
						mmad_pkg::KIND_NOP: dec_outcome = mmad_pkg::OUT_NOP;
						mmad_pkg::KIND_RAM: begin
							dec_we      = 1'b1;
							dec_outcome = mmad_pkg::OUT_MEM_WRITE;
						end
						mmad_pkg::KIND_ROM: dec_outcome = mmad_pkg::OUT_ROM_BLOCKED;
						default: begin
							dec_outcome = mmad_pkg::OUT_HANDLER_WRITE;
							dec_hid     = wr_hit.handler;
							dec_hoff    = addr16 - wr_hit.addr_lo;
							dec_hdata   = data_q;
						end
					endcase
				end
			end
			mmad_pkg::CMD_LOAD_READ,
			mmad_pkg::CMD_LOAD_WRITE: dec_outcome = mmad_pkg::OUT_LOAD_ACK;
			mmad_pkg::CMD_PRELOAD: begin
				dec_we      = 1'b1;
				dec_outcome = mmad_pkg::OUT_LOAD_ACK;
			end
			default: dec_outcome = mmad_pkg::OUT_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[maddr_q] <= data_q;
		end
		if (mem_re) begin
			mem_rdata_q <= mem_q[maddr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mmad_pkg::ST_DECODE) begin
			rd_sel_q      <= dec_rd_sel;
			res_outcome_q <= dec_outcome;
			res_hid_q     <= dec_hid;
			res_hoff_q    <= dec_hoff;
			res_hdata_q   <= dec_hdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			read_data      <= rd_sel_q ? mem_rdata_q : 8'd0;
			outcome        <= res_outcome_q;
			handler_id     <= res_hid_q;
			handler_offset <= res_hoff_q;
			handler_data   <= res_hdata_q;
		end
	end

	assign rsp_valid = rsp_valid_q;

`ifndef NO_ASSERTIONS
	a_xfer_to_decode: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> state_q == mmad_pkg::ST_DECODE)
		else $error("request transfer not followed by decode");

	a_decode_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mmad_pkg::ST_DECODE |=> state_q == mmad_pkg::ST_RESP)
		else $error("decode not followed by response stage");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == mmad_pkg::ST_RESP)
		else $error("response raised outside response stage");

	a_hdata_only_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (outcome != mmad_pkg::OUT_HANDLER_WRITE) |-> handler_data == 8'd0)
		else $error("handler data on a non handler write");

	a_mem_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re || mem_we) |-> !(mem_re && mem_we) && !req_xfer)
		else $error("memory access overlaps another access or a transfer");
`endif

endmodule
